### rtl/aep_pkg.sv
// shared types and constants for the adaptive enqueue placement block
// no dependencies; imported by aep_update and adaptive_enqueue_placement
package aep_pkg;

   localparam int unsigned PEN_W   = 21;
   localparam int unsigned TRACK_W = 6;
   localparam int unsigned LIMIT_W = 5;
   localparam int unsigned CSR_W   = 21;
   localparam int unsigned CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LIMIT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY_CEILING = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 5'd20;
   localparam logic [PEN_W-1:0]   CEILING_RESET = 21'd1048576;
   localparam logic [PEN_W-1:0]   PENALTY_FLOOR = 21'd1;
   localparam logic [PEN_W-1:0]   PENALTY_MAX   = 21'h1FFFFF;

   typedef struct packed {
      logic [3:0] requester;
      logic       shared_free;
   } req_type;

   typedef struct packed {
      logic             to_shared;
      logic [PEN_W-1:0] penalty_now;
      logic [PEN_W-1:0] bias_now;
   } rsp_type;

   typedef struct packed {
      logic [PEN_W-1:0]          bias;
      logic [PEN_W-1:0]          penalty;
      logic signed [TRACK_W-1:0] track;
   } slot_state_type;

   localparam int unsigned STATE_W = $bits(slot_state_type);

   localparam slot_state_type STATE_RESET = '{
      bias:    '0,
      penalty: PENALTY_FLOOR,
      track:   '0
   };

endpackage

### rtl/aep_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read returns the old contents on a same-address write
module aep_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/aep_update.sv
// per-slot placement decision and state update, pure combinational
// depends on aep_pkg for the slot state type and constants
module aep_update
   import aep_pkg::*;
(
   input  slot_state_type     cur_state,
   input  logic               shared_free,
   input  logic [LIMIT_W-1:0] track_limit,
   input  logic [PEN_W-1:0]   penalty_ceiling,
   output slot_state_type     nxt_state,
   output logic               to_shared
);

   logic signed [TRACK_W:0] track_up;
   logic signed [TRACK_W:0] track_dn;
   logic signed [TRACK_W:0] lim_s;
   logic [PEN_W:0]          pen_dbl;
   logic [PEN_W-1:0]        pen_new;

   always_comb begin
      track_up = signed'({cur_state.track[TRACK_W-1], cur_state.track}) + 7'sd1;
      track_dn = signed'({cur_state.track[TRACK_W-1], cur_state.track}) - 7'sd1;
      lim_s    = signed'({2'b00, track_limit});
      pen_dbl  = {cur_state.penalty, 1'b0};
      pen_new  = cur_state.penalty;
      nxt_state = cur_state;
      to_shared = 1'b0;

      if (cur_state.bias != '0) begin
         // still biased toward the local queue
         nxt_state.bias = cur_state.bias - 21'd1;
      end else if (shared_free) begin
         to_shared = 1'b1;
         nxt_state.track = track_up[TRACK_W-1:0];
         if (track_up > lim_s) begin
            if (cur_state.penalty > PENALTY_FLOOR) begin
               nxt_state.penalty = cur_state.penalty >> 1;
            end
            nxt_state.track = '0;
         end
      end else begin
         nxt_state.track = track_dn[TRACK_W-1:0];
         if (track_dn < -lim_s) begin
            if (cur_state.penalty < penalty_ceiling) begin
               // saturate when doubling runs past the field width
               pen_new = pen_dbl[PEN_W] ? PENALTY_MAX : pen_dbl[PEN_W-1:0];
            end
            nxt_state.track = '0;
         end
         nxt_state.penalty = pen_new;
         nxt_state.bias    = pen_new;
      end
   end

endmodule

### rtl/adaptive_enqueue_placement.sv
// adaptive enqueue placement: a request passes stage 1 and the output register;
// one transaction per cycle unless stalled, even back-to-back hits on the same slot
// (the slot state ram read is registered; a one-entry bypass covers the write in flight)
// reset is synchronous: valid bits for all slots clear at once, so every slot reads
// as bias 0, penalty 1, track 0 right after reset; registers return to 20 and 1048576
// depends on aep_pkg, aep_ram and aep_update
module adaptive_enqueue_placement
   import aep_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // register write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // configuration registers
   logic [LIMIT_W-1:0] limit_ff;
   logic [PEN_W-1:0]   ceiling_ff;

   // stage 1: request waiting on its ram read
   logic              s1_valid_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic              s1_free_ff;
   logic              s1_hit_ff;

   // bypass of the slot written on the edge the stage 1 item was accepted
   logic              bp_valid_ff;
   logic [SLOT_W-1:0] bp_slot_ff;
   slot_state_type    bp_state_ff;

   // per-slot written flags; an unwritten slot reads as its reset state
   logic [NUM_SLOTS-1:0] slot_valid_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic              out_free;
   logic              advance;
   logic              accept;
   logic              s1_fire;
   logic [SLOT_W-1:0] req_slot;
   logic [STATE_W-1:0] ram_rdata;
   slot_state_type    cur_state;
   slot_state_type    nxt_state;
   logic              nxt_shared;

   // output register frees when empty or when its transaction is taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = !s1_valid_ff || out_free;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign s1_fire   = s1_valid_ff && out_free;

   // requesters past the last slot fold onto the last slot
   always_comb begin
      if (int'(req_data.requester) >= int'(NUM_SLOTS)) begin
         req_slot = SLOT_W'(NUM_SLOTS - 1);
      end else begin
         req_slot = SLOT_W'(req_data.requester);
      end
   end

   aep_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_slot_ff),
      .wr_data (nxt_state),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (ram_rdata)
   );

   // newest copy of the slot: bypass first, then ram, then reset state
   always_comb begin
      if (bp_valid_ff && (bp_slot_ff == s1_slot_ff)) begin
         cur_state = bp_state_ff;
      end else if (s1_hit_ff) begin
         cur_state = slot_state_type'(ram_rdata);
      end else begin
         cur_state = STATE_RESET;
      end
   end

   aep_update u_update (
      .cur_state       (cur_state),
      .shared_free     (s1_free_ff),
      .track_limit     (limit_ff),
      .penalty_ceiling (ceiling_ff),
      .nxt_state       (nxt_state),
      .to_shared       (nxt_shared)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         ceiling_ff <= CEILING_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_TRACK_LIMIT) begin
            limit_ff <= csr_wdata[LIMIT_W-1:0];
         end else if (csr_index == CSR_PENALTY_CEILING) begin
            ceiling_ff <= csr_wdata[PEN_W-1:0];
         end
      end
   end

   // stage 1 control and the written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         bp_valid_ff   <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff <= req_valid;
            bp_valid_ff <= s1_fire;
         end
         if (s1_fire) begin
            slot_valid_ff[s1_slot_ff] <= 1'b1;
         end
      end
   end

   // stage 1 payload and bypass data
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_slot_ff  <= req_slot;
         s1_free_ff  <= req_data.shared_free;
         // flag sampled before this edge's write; the bypass covers that write
         s1_hit_ff   <= slot_valid_ff[req_slot];
         bp_slot_ff  <= s1_slot_ff;
         bp_state_ff <= nxt_state;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff.to_shared   <= nxt_shared;
         rsp_data_ff.penalty_now <= nxt_state.penalty;
         rsp_data_ff.bias_now    <= nxt_state.bias;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // penalty never falls to zero
   a_penalty_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.penalty_now != '0))
      else $error("penalty reported as zero");

   // a shared placement only happens with no bias left
   a_shared_no_bias: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.to_shared) |-> (rsp_data_ff.bias_now == '0))
      else $error("shared placement with bias remaining");

   // every state write is visible to the next item through the bypass
   a_bypass_load: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (bp_valid_ff && (bp_slot_ff == $past(s1_slot_ff))))
      else $error("bypass missed a state write");

   // a blocked stage 1 item holds its slot
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_slot_ff)))
      else $error("stage 1 item lost while blocked");

endmodule
